// ===== rtl/pba_pkg.sv =====
// Shared types and constants of the page bitmap allocator.
package pba_pkg;

  localparam int ACT_W      = 2;
  localparam int PAGE_W     = 15;
  localparam int OFF_W      = 6;
  localparam int WORD_W     = 64;
  localparam int FIELD_PAGES = 32768;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_SET   = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_TEST  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic rd;
    logic eval;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_bad;
    logic eval_done;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/pba_ctrl.sv =====
// Controller state machine of the page bitmap allocator.
module pba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pba_pkg::sts_t sts,
  output pba_pkg::cmd_t cmd
);

  pba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pba_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      pba_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      pba_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_bad ? pba_pkg::ST_DONE : pba_pkg::ST_READ;
        end
      end
      pba_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = pba_pkg::ST_EVAL;
      end
      pba_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.eval_done ? pba_pkg::ST_DONE : pba_pkg::ST_READ;
      end
      pba_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = pba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pba_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/pba_datapath.sv =====
// Datapath of the page bitmap allocator: used map memory, scan logic, result register.
module pba_datapath #(
  parameter int LIMIT     = 32768,
  parameter int MEM_WORDS = 512,
  parameter int AW        = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pba_pkg::cmd_t                     cmd,
  output pba_pkg::sts_t                     sts,
  input  logic [pba_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pba_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam logic [pba_pkg::PAGE_W:0] LIMIT_V = (pba_pkg::PAGE_W+1)'(LIMIT);
  localparam logic [AW-1:0]            LAST_W  = AW'(MEM_WORDS - 1);

  logic [pba_pkg::WORD_W-1:0] mem [MEM_WORDS];

  logic [AW-1:0]                 addr_r;
  logic [pba_pkg::WORD_W-1:0]    rdata_r;
  pba_pkg::action_t              act_r;
  logic [pba_pkg::PAGE_W-1:0]    page_r;
  logic                          first_r;
  logic                          bit_r;
  logic [pba_pkg::PAGE_W-1:0]    res_page_r;
  logic                          res_status_r;
  logic                          res_bit_r;
  logic                          out_valid_r;
  logic [pba_pkg::PAGE_W-1:0]    out_page_r;
  logic                          out_status_r;
  logic                          out_bit_r;

  pba_pkg::action_t              in_act;
  logic [pba_pkg::PAGE_W-1:0]    in_page;
  logic [pba_pkg::OFF_W-1:0]     off;
  logic [pba_pkg::WORD_W-1:0]    mask;
  logic [pba_pkg::WORD_W-1:0]    freebits;
  logic [pba_pkg::OFF_W-1:0]     hit_b;
  logic                          hit;
  logic [pba_pkg::PAGE_W-1:0]    cand;
  logic                          cand_over;
  logic                          last_word;
  logic                          bit_now;
  logic                          we;
  logic [pba_pkg::WORD_W-1:0]    wdata;
  logic                          done;
  logic [pba_pkg::PAGE_W-1:0]    done_page;
  logic                          done_status;

  assign in_act  = pba_pkg::action_t'(in_tdata[pba_pkg::ACT_W-1:0]);
  assign in_page = in_tdata[pba_pkg::ACT_W +: pba_pkg::PAGE_W];

  // Any page outside the scan limit is rejected before touching the map.
  assign sts.in_bad = ({1'b0, in_page} >= LIMIT_V);

  assign off       = page_r[pba_pkg::OFF_W-1:0];
  assign mask      = first_r ? ({pba_pkg::WORD_W{1'b1}} << off) : {pba_pkg::WORD_W{1'b1}};
  assign freebits  = ~rdata_r & mask;
  assign hit       = |freebits;
  assign last_word = (addr_r == LAST_W);
  assign bit_now   = first_r ? rdata_r[off] : bit_r;
  assign cand      = pba_pkg::PAGE_W'({addr_r, hit_b});
  assign cand_over = ({1'b0, cand} >= LIMIT_V);

  // Lowest free bit of the current word.
  always_comb begin
    hit_b = '0;
    for (int i = pba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (freebits[i]) begin
        hit_b = pba_pkg::OFF_W'(i);
      end
    end
  end

  always_comb begin
    we          = 1'b0;
    wdata       = rdata_r;
    done        = 1'b1;
    done_page   = page_r;
    done_status = 1'b0;
    case (act_r)
      pba_pkg::ACT_ALLOC: begin
        if (hit && !cand_over) begin
          we        = 1'b1;
          wdata     = rdata_r | (pba_pkg::WORD_W'(1) << hit_b);
          done_page = cand;
        end else if (hit || last_word) begin
          done_page   = '0;
          done_status = 1'b1;
        end else begin
          done = 1'b0;
        end
      end
      pba_pkg::ACT_SET: begin
        we    = 1'b1;
        wdata = rdata_r | (pba_pkg::WORD_W'(1) << off);
      end
      pba_pkg::ACT_FREE: begin
        we    = 1'b1;
        wdata = rdata_r & ~(pba_pkg::WORD_W'(1) << off);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign sts.eval_done = done;
  assign sts.clr_last  = last_word;
  assign sts.out_busy  = out_valid_r && !out_tready;

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[addr_r] <= '0;
    end else if (cmd.eval && we) begin
      mem[addr_r] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.accept) begin
      addr_r <= AW'(in_page[pba_pkg::PAGE_W-1:pba_pkg::OFF_W]);
    end else if ((cmd.clr_step || (cmd.eval && !done)) && !last_word) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r        <= in_act;
      page_r       <= in_page;
      first_r      <= 1'b1;
      res_page_r   <= (in_act == pba_pkg::ACT_ALLOC) ? '0 : in_page;
      res_status_r <= 1'b1;
      res_bit_r    <= 1'b0;
    end else if (cmd.eval) begin
      first_r <= 1'b0;
      bit_r   <= bit_now;
      if (done) begin
        res_page_r   <= done_page;
        res_status_r <= done_status;
        res_bit_r    <= bit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_page_r   <= res_page_r;
      out_status_r <= res_status_r;
      out_bit_r    <= res_bit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r, out_status_r, out_page_r};

`ifndef ASSERT_OFF
  // A new result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_tready))
    else $error("result loaded while output stalled");

  // The scan only moves on while words remain.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && !done) |-> !last_word)
    else $error("scan advanced past last map word");

  // A successful result always names a page inside the map.
  a_ok_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_status_r) |-> ({1'b0, out_page_r} < LIMIT_V))
    else $error("ok result with page outside map");

  // A read is always followed by its evaluation.
  a_rd_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> cmd.eval)
    else $error("map read not evaluated");
`endif

endmodule

// ===== rtl/page_bitmap_allocator.sv =====
// Top level of the page bitmap allocator: one used bit per page, allocate/set/free/test.
// Set, free and test go through accept, read, evaluate and load before the result is valid;
// a request naming a page outside the map goes from accept to load, and an allocate repeats
// read and evaluate for each extra word. One request at a time: accept, read, evaluate, load.
// Reset: synchronous, active low; a clearing pass then zeroes one map word per cycle,
// ceil(min(PAGE_COUNT, 32768) / 64) words in all, during which no request is accepted.
module page_bitmap_allocator #(
  parameter int PAGE_COUNT = 32768
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pba_pkg::IN_DATA_W-1:0]  in_tdata,   // action[1:0], page[16:2], zeros[23:17]
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pba_pkg::OUT_DATA_W-1:0] out_tdata   // found_page[14:0], status[15],
                                                      // bit_value[16], zeros[23:17]
);

  // Only pages that fit the 15-bit page field can be named or allocated, so the
  // map stores no more than that many bits.
  localparam int LIMIT     = (PAGE_COUNT < pba_pkg::FIELD_PAGES) ? PAGE_COUNT
                                                                 : pba_pkg::FIELD_PAGES;
  localparam int MEM_WORDS = (LIMIT + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  pba_pkg::cmd_t cmd;
  pba_pkg::sts_t sts;

  // The controller sequences each transaction: accept, read a map word, evaluate it
  // (write back, finish or move on to the next word), then hand the result to the output
  // register once that register is free; a page outside the map skips read and evaluate.
  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the map memory, the free-bit search of one word and the
  // output register that decouples the result side from the request side.
  pba_datapath #(
    .LIMIT     (LIMIT),
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/pba_checker.sv =====
// Checker for the page bitmap allocator: predicts each result and compares it with the block's.
module pba_checker #(
  parameter int PAGE_COUNT = 32768
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pba_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pba_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             pending
);

  // Pages above the 15-bit field can never be reached, whatever the map size.
  localparam int SCAN_END = (PAGE_COUNT < pba_pkg::FIELD_PAGES) ? PAGE_COUNT
                                                                : pba_pkg::FIELD_PAGES;

  typedef struct packed {
    logic [pba_pkg::PAGE_W-1:0] found_page;
    logic                       status;
    logic                       bit_value;
  } page_result_t;

  logic         used_pages [0:pba_pkg::FIELD_PAGES-1];
  page_result_t awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Applies one request to the shadow map and returns the result it should produce.
  function automatic page_result_t apply_request(pba_pkg::action_t act,
                                                 logic [pba_pkg::PAGE_W-1:0] page);
    page_result_t res;
    int           p;
    bit           in_map;
    in_map        = (int'(page) < PAGE_COUNT);
    res.found_page = page;
    res.status     = 1'b0;
    res.bit_value  = in_map ? used_pages[page] : 1'b0;
    case (act)
      pba_pkg::ACT_ALLOC: begin
        for (p = int'(page); p < SCAN_END; p++) begin
          if (!used_pages[p]) break;
        end
        if (p < SCAN_END) begin
          used_pages[p]  = 1'b1;
          res.found_page = p[pba_pkg::PAGE_W-1:0];
        end else begin
          res.found_page = '0;
          res.status     = 1'b1;
        end
      end
      pba_pkg::ACT_SET: begin
        if (in_map) used_pages[page] = 1'b1;
        else res.status = 1'b1;
      end
      pba_pkg::ACT_FREE: begin
        if (in_map) used_pages[page] = 1'b0;
        else res.status = 1'b1;
      end
      default: begin
        if (!in_map) res.status = 1'b1;
      end
    endcase
    return res;
  endfunction

  task automatic report_field(string field, int want, int got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("pba_checker: %s mismatch at %0t, expected %0d, got %0d",
               field, $realtime, want, got);
    end
  endtask

  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < pba_pkg::FIELD_PAGES; i++) used_pages[i] = 1'b0;
      awaited_results.delete();
    end else begin
      // Results are matched before requests: a request taken at this edge cannot
      // have produced the result that leaves at the same edge.
      if (out_tvalid && out_tready) begin
        got.found_page = out_tdata[pba_pkg::PAGE_W-1:0];
        got.status     = out_tdata[pba_pkg::PAGE_W];
        got.bit_value  = out_tdata[pba_pkg::PAGE_W+1];
        if (awaited_results.size() == 0) begin
          report_field("unexpected result, found_page", -1, got.found_page);
        end else begin
          want = awaited_results.pop_front();
          if (got.found_page !== want.found_page)
            report_field("found_page", want.found_page, got.found_page);
          if (got.status !== want.status)
            report_field("status", want.status, got.status);
          if (got.bit_value !== want.bit_value)
            report_field("bit_value", want.bit_value, got.bit_value);
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_request(
            pba_pkg::action_t'(in_tdata[pba_pkg::ACT_W-1:0]),
            in_tdata[pba_pkg::ACT_W +: pba_pkg::PAGE_W]));
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the page bitmap allocator testbench: clock, reset, request and result traffic, verdict.
module tb_top;

  // The slowest allocate walks all 512 map words, and the clearing pass after reset
  // zeroes all 512 as well; neither these nor the long result hold-off below come
  // near the limit.
  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int HOLD_OFF_AFTER  = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PAD_W           = pba_pkg::IN_DATA_W - pba_pkg::PAGE_W - pba_pkg::ACT_W;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [pba_pkg::IN_DATA_W-1:0]  in_tdata;    // action[1:0], page[16:2], zeros[23:17]
  logic                           out_tvalid;
  logic                           out_tready;
  logic [pba_pkg::OUT_DATA_W-1:0] out_tdata;   // found_page[14:0], status[15],
                                               // bit_value[16], zeros[23:17]

  int fail_count;
  int pending;
  int idle_cycles;
  int results_taken;
  int burst_left;

  page_bitmap_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pba_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Activity tracking for the watchdog and for the receiver's hold-off trigger.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles   <= 0;
      results_taken <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) results_taken <= results_taken + 1;
    end
  end

  // The watchdog ends a run that has stopped moving transactions.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side. Ready follows a 16-bit pattern that is played four times and
  // then redrawn; a quarter of the patterns never stall. Once, after a few hundred
  // results, ready is held low for a long stretch so the block backs up and
  // stops taking requests while the request side keeps offering.
  initial begin
    int          hold_left;
    bit          held;
    logic [15:0] stall_pattern;
    int          pattern_pos;
    out_tready    = 1'b0;
    hold_left     = 0;
    held          = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_pos   = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && results_taken >= HOLD_OFF_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pattern_pos == 0) begin
          stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        out_tready  <= stall_pattern[pattern_pos % 16];
        pattern_pos = (pattern_pos + 1) % 64;
      end
    end
  end

  // Offers one request from a falling edge; returns at the falling edge after the
  // transaction, or after the random gap in which valid drops between bursts.
  // Requests come in bursts; occasional long bursts give stretches with no idling.
  task automatic offer_request(pba_pkg::action_t act, int page);
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, page[pba_pkg::PAGE_W-1:0], act};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(0, 7);
    end
  endtask

  initial begin
    int               window_base;
    int               window_len;
    int               page;
    int               pick;
    pba_pkg::action_t act;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    burst_left = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: fresh map, allocation across a word boundary, freeing a
    // page twice, setting a page twice, and running out of free pages at the
    // very top of the map.
    offer_request(pba_pkg::ACT_TEST, 0);
    offer_request(pba_pkg::ACT_ALLOC, 0);
    offer_request(pba_pkg::ACT_ALLOC, 0);
    offer_request(pba_pkg::ACT_TEST, 0);
    offer_request(pba_pkg::ACT_SET, 63);
    offer_request(pba_pkg::ACT_SET, 64);
    offer_request(pba_pkg::ACT_ALLOC, 62);
    offer_request(pba_pkg::ACT_ALLOC, 62);
    offer_request(pba_pkg::ACT_FREE, 0);
    offer_request(pba_pkg::ACT_FREE, 0);
    offer_request(pba_pkg::ACT_SET, 5);
    offer_request(pba_pkg::ACT_SET, 5);
    offer_request(pba_pkg::ACT_ALLOC, 32767);
    offer_request(pba_pkg::ACT_ALLOC, 32767);
    offer_request(pba_pkg::ACT_TEST, 32767);
    offer_request(pba_pkg::ACT_FREE, 32767);
    offer_request(pba_pkg::ACT_ALLOC, 32766);
    offer_request(pba_pkg::ACT_ALLOC, 32766);
    offer_request(pba_pkg::ACT_ALLOC, 32766);
    offer_request(pba_pkg::ACT_SET, 16'h5555 & 16'h7FFF);
    offer_request(pba_pkg::ACT_TEST, 16'h2AAA);
    offer_request(pba_pkg::ACT_TEST, 16'h5555 & 16'h7FFF);

    // Random part. Most requests land in a small hot window so the map gets
    // dense there and allocations have to walk across full words; some land
    // near the top of the map so scans run off the end and fail, and the rest
    // are spread over the whole page range.
    window_base = 0;
    window_len  = 64;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        window_len  = $urandom_range(64, 512);
        window_base = ($urandom_range(0, 3) == 0)
                      ? pba_pkg::FIELD_PAGES - window_len
                      : $urandom_range(0, pba_pkg::FIELD_PAGES - window_len);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6) page = window_base + $urandom_range(0, window_len - 1);
      else if (pick == 7) page = pba_pkg::FIELD_PAGES - 128 + $urandom_range(0, 127);
      else page = $urandom_range(0, pba_pkg::FIELD_PAGES - 1);
      pick = $urandom_range(0, 9);
      if (pick <= 3) act = pba_pkg::ACT_ALLOC;
      else if (pick <= 5) act = pba_pkg::ACT_SET;
      else if (pick <= 7) act = pba_pkg::ACT_FREE;
      else act = pba_pkg::ACT_TEST;
      offer_request(act, page);
    end
    in_tvalid <= 1'b0;

    // Every request gives exactly one result, so the run is drained once the
    // checker waits for nothing; a short tail catches any stray extra result.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
